// ----- hdl/elevation_grid_slope_core_assert.svh -----
// Assertion macros for the slope core.
`ifndef ELEVATION_GRID_SLOPE_CORE_ASSERT_SVH
`define ELEVATION_GRID_SLOPE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define EGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/egs_pkg.sv -----
// ---------------------------------------------------------------------------
// egs_pkg
// Shared types and the arctangent table for the terrain slope core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package egs_pkg;

    // One grid cell: validity and height in millimetres.
    typedef struct packed {
        logic               ok;
        logic signed [19:0] h;
    } t_cell;

    // Request into the slope unit.
    typedef struct packed {
        logic               ok;
        logic signed [22:0] nx;
        logic signed [22:0] ny;
        logic        [15:0] cs;
    } t_slope_req;

    // Status out of the slope unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_slope_stat;

    // atan(2^-i) in units of 2^-16 centidegree.
    function automatic logic signed [31:0] egs_atan(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd294912000;
            5'd1:    v = 32'sd174096719;
            5'd2:    v = 32'sd91987925;
            5'd3:    v = 32'sd46694507;
            5'd4:    v = 32'sd23437865;
            5'd5:    v = 32'sd11730358;
            5'd6:    v = 32'sd5866610;
            5'd7:    v = 32'sd2933484;
            5'd8:    v = 32'sd1466764;
            5'd9:    v = 32'sd733385;
            5'd10:   v = 32'sd366693;
            5'd11:   v = 32'sd183346;
            5'd12:   v = 32'sd91673;
            5'd13:   v = 32'sd45837;
            5'd14:   v = 32'sd22918;
            5'd15:   v = 32'sd11459;
            5'd16:   v = 32'sd5730;
            5'd17:   v = 32'sd2865;
            5'd18:   v = 32'sd1432;
            5'd19:   v = 32'sd716;
            5'd20:   v = 32'sd358;
            5'd21:   v = 32'sd179;
            5'd22:   v = 32'sd90;
            5'd23:   v = 32'sd45;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/egs_row_store.sv -----
// ---------------------------------------------------------------------------
// egs_row_store
// Previous-row and older-row cell memories, one write and one registered
// read port each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module egs_row_store #(
    parameter int DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  egs_pkg::t_cell               i_prev_wdata,
    input  egs_pkg::t_cell               i_older_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_prev_raddr,
    input  logic [$clog2(DEPTH)-1:0]     i_older_raddr,
    output egs_pkg::t_cell               o_prev_rdata,
    output egs_pkg::t_cell               o_older_rdata
);
    import egs_pkg::*;

    t_cell r_prev_mem  [DEPTH];
    t_cell r_older_mem [DEPTH];
    t_cell r_prev_q;
    t_cell r_older_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_prev_mem[i_waddr]  <= i_prev_wdata;
            r_older_mem[i_waddr] <= i_older_wdata;
        end
        r_prev_q  <= r_prev_mem[i_prev_raddr];
        r_older_q <= r_older_mem[i_older_raddr];
    end

    assign o_prev_rdata  = r_prev_q;
    assign o_older_rdata = r_older_q;

endmodule

// ----- hdl/egs_slope_unit.sv -----
// ---------------------------------------------------------------------------
// egs_slope_unit
// Shared square, integer square root and CORDIC arctangent for one slope.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module egs_slope_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  egs_pkg::t_slope_req   i_req,
    input  logic                  i_ack,
    output egs_pkg::t_slope_stat  o_stat,
    output logic [13:0]           o_slope,
    output logic                  o_slope_valid
);
    import egs_pkg::*;

    localparam logic [2:0] U_IDLE  = 3'd0;
    localparam logic [2:0] U_SQX   = 3'd1;
    localparam logic [2:0] U_SQY   = 3'd2;
    localparam logic [2:0] U_SUM   = 3'd3;
    localparam logic [2:0] U_SQRT  = 3'd4;
    localparam logic [2:0] U_CINIT = 3'd5;
    localparam logic [2:0] U_CORD  = 3'd6;
    localparam logic [2:0] U_FIN   = 3'd7;

    logic [2:0]         r_state;
    logic               r_done;
    logic [21:0]        r_ax, r_ay;
    logic [15:0]        r_cs;
    logic [43:0]        r_prod, r_acc;
    logic [63:0]        r_v, r_root, r_bit;
    logic signed [36:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic [4:0]         r_i;
    logic [13:0]        r_slope;
    logic               r_valid;

    logic [21:0]        w_mul_a;
    logic [43:0]        w_mul;
    logic [63:0]        w_trial;
    logic signed [36:0] w_dx, w_dy;
    logic signed [31:0] w_at;
    logic signed [32:0] w_zr;

    assign w_mul_a = (r_state == U_SQX) ? r_ax : r_ay;
    assign w_mul   = w_mul_a * w_mul_a;
    assign w_trial = r_root + r_bit;
    assign w_dx    = r_y >>> r_i;
    assign w_dy    = r_x >>> r_i;
    assign w_at    = egs_atan(r_i);
    assign w_zr    = ((r_z[31] ? 33'sd0 : 33'(r_z)) + 33'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else if (r_done) begin
            if (i_ack) begin
                r_done <= 1'b0;
            end
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_ax <= i_req.nx[22] ? 22'(-i_req.nx) : 22'(i_req.nx);
                        r_ay <= i_req.ny[22] ? 22'(-i_req.ny) : 22'(i_req.ny);
                        r_cs <= i_req.cs;
                        if (i_req.ok) begin
                            r_state <= U_SQX;
                        end else begin
                            r_slope <= '0;
                            r_valid <= 1'b0;
                            r_done  <= 1'b1;
                        end
                    end
                end
                U_SQX: begin
                    r_prod  <= w_mul;
                    r_state <= U_SQY;
                end
                U_SQY: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= U_SUM;
                end
                U_SUM: begin
                    r_v     <= {r_acc + r_prod, 20'd0};
                    r_root  <= '0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_state <= U_SQRT;
                end
                U_SQRT: begin
                    // one root bit per cycle
                    if (r_v >= w_trial) begin
                        r_v    <= r_v - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_state <= U_CINIT;
                    end
                end
                U_CINIT: begin
                    if (r_root == 64'd0) begin
                        r_slope <= '0;
                        r_valid <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_x     <= {10'd0, r_cs, 11'd0};
                        r_y     <= r_root[36:0];
                        r_z     <= '0;
                        r_i     <= '0;
                        r_state <= U_CORD;
                    end
                end
                U_CORD: begin
                    if (!r_y[36]) begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end else begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    // round to centidegrees, clamp negative angles to zero and clamp at vertical
                    r_slope <= (w_zr > 33'sd9000) ? 14'd9000 : 14'(w_zr);
                    r_valid <= 1'b1;
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_stat.busy   = r_done || (r_state != U_IDLE);
    assign o_stat.done   = r_done;
    assign o_slope       = r_slope;
    assign o_slope_valid = r_valid;

endmodule

// ----- hdl/elevation_grid_slope_core.sv -----
// ---------------------------------------------------------------------------
// elevation_grid_slope_core
// Streaming central-difference terrain slope over a raster of height cells.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | height, confidence, finite
//  out     | output    | o_out_valid / i_out_ready  | column, grid_row, slope, ...
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
//  An item passes an accept state, the row-store access states RD0 to RD3 and a
//  final dispatch state, and each of its results then passes the shared slope
//  unit (dispatch, squares and sum, root bits, setup, CORDIC_STEPS CORDIC
//  iterations at one iteration a cycle, rounding, hand-off) before the next.
//  A result with no gradient is done at dispatch; a flat one skips the CORDIC.
//  Reset is synchronous active low; the row stores are not cleared.
//  An output stall holds the slope unit with its finished result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elevation_grid_slope_core_assert.svh"
module elevation_grid_slope_core #(
    parameter int MAX_WIDTH    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [19:0] i_height,
    input  logic        [7:0]  i_confidence,
    input  logic               i_finite,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [9:0]  o_column,
    output logic        [15:0] o_grid_row,
    output logic        [13:0] o_slope,
    output logic               o_slope_valid,
    output logic               o_run_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    import egs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE   = 2'd2;
    localparam logic [1:0] REG_CONF_FLOOR  = 2'd3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_RD3  = 3'd4;
    localparam logic [2:0] S_JOB  = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;

    typedef struct packed {
        logic               ok;
        logic signed [22:0] n;
    } t_grad;

    logic [10:0] r_cfg_w;
    logic [15:0] r_cfg_h, r_cfg_cs;
    logic [7:0]  r_cfg_floor;

    logic [2:0]    r_state;
    logic [CW-1:0] r_col, r_c, r_w;
    logic [15:0]   r_row, r_r, r_h, r_cs;
    t_cell         r_held0, r_held1, r_pl, r_cl, r_cur;
    t_cell         r_ctr, r_dn, r_rgt, r_d2, r_l2;
    logic [2:0]    r_jobs;

    logic          r_out_vld, r_out_last, r_out_sv;
    logic [9:0]    r_out_col;
    logic [15:0]   r_out_row;
    logic [13:0]   r_out_slope;
    logic          r_job_last;
    logic [CW-1:0] r_job_col;
    logic [15:0]   r_job_row;

    logic [CW-1:0] w_w_eff;
    logic [15:0]   w_h_eff, w_cs_eff;
    t_cell         w_prev_rd, w_older_rd;
    logic [AW-1:0] w_prev_ra, w_older_ra;
    logic          w_accept, w_start, w_take;
    t_slope_req    w_req;
    t_slope_stat   w_stat;
    logic [13:0]   w_slope;
    logic          w_slope_valid;
    logic [2:0]    w_jsel;
    logic [CW-1:0] w_jcol;
    logic [15:0]   w_jrow;
    t_cell         w_cc, w_l, w_rr, w_d, w_u;
    logic          w_hl, w_hr, w_hd, w_hu;
    t_grad         w_gx, w_gy;
    logic [16:0]   w_r_inc;
    logic [CW-1:0] w_c_inc;

    function automatic t_grad grad(input t_cell c, input logic hl, input t_cell l,
                                   input logic hr, input t_cell r);
        t_grad g;
        g.ok = 1'b1;
        if (hl && hr && l.ok && r.ok) begin
            g.n = 23'(r.h) - 23'(l.h);
        end else if (hr && r.ok) begin
            g.n = (23'(r.h) - 23'(c.h)) <<< 1;
        end else if (hl && l.ok) begin
            g.n = (23'(c.h) - 23'(l.h)) <<< 1;
        end else begin
            g.ok = 1'b0;
            g.n  = '0;
        end
        return g;
    endfunction

    // effective geometry
    always_comb begin
        if (r_cfg_w == 11'd0) begin
            w_w_eff = CW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            w_w_eff = CW'(MAX_WIDTH);
        end else begin
            w_w_eff = CW'(r_cfg_w);
        end
    end
    assign w_h_eff  = (r_cfg_h == 16'd0) ? 16'd1 : r_cfg_h;
    assign w_cs_eff = (r_cfg_cs == 16'd0) ? 16'd1 : r_cfg_cs;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_r_inc     = {1'b0, r_r} + 17'd1;
    assign w_c_inc     = r_c + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= 11'd1;
            r_cfg_h     <= 16'd1;
            r_cfg_cs    <= 16'd100;
            r_cfg_floor <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_cfg_w     <= i_cfg_data[10:0];
                REG_GRID_HEIGHT: r_cfg_h     <= i_cfg_data;
                REG_CELL_SIZE:   r_cfg_cs    <= i_cfg_data;
                REG_CONF_FLOOR:  r_cfg_floor <= i_cfg_data[7:0];
                default:         r_cfg_w     <= r_cfg_w;
            endcase
        end
    end

    // row store addressing: centre first, then right / older-left, then left-two
    always_comb begin
        case (r_state)
            S_RD0:   w_prev_ra = AW'(r_c);
            S_RD1:   w_prev_ra = AW'(r_c + CW'(1));
            default: w_prev_ra = AW'(r_c - CW'(2));
        endcase
        w_older_ra = (r_state == S_RD0) ? AW'(r_c) : AW'(r_c - CW'(1));
    end

    egs_row_store #(
        .DEPTH(MAX_WIDTH)
    ) u_store (
        .i_clk         (i_clk),
        .i_we          (r_state == S_RD3),
        .i_waddr       (AW'(r_c)),
        .i_prev_wdata  (r_cur),
        .i_older_wdata (r_ctr),
        .i_prev_raddr  (w_prev_ra),
        .i_older_raddr (w_older_ra),
        .o_prev_rdata  (w_prev_rd),
        .o_older_rdata (w_older_rd)
    );

    // pick the first pending result and assemble its neighbourhood
    always_comb begin
        w_cc = r_cur; w_l = r_cl; w_rr = r_cur; w_d = r_ctr; w_u = r_cur;
        w_hl = 1'b0; w_hr = 1'b0; w_hd = 1'b0; w_hu = 1'b0;
        w_jcol = r_c; w_jrow = r_r; w_jsel = 3'b000;
        if (r_jobs[0]) begin
            w_jsel = 3'b001;
            w_cc = r_ctr; w_hl = (r_c != '0); w_l = r_pl;
            w_hr = (w_c_inc < r_w); w_rr = r_rgt;
            w_hd = (r_r >= 16'd2); w_d = r_dn; w_hu = 1'b1; w_u = r_cur;
            w_jrow = r_r - 16'd1;
        end else if (r_jobs[1]) begin
            w_jsel = 3'b010;
            w_cc = r_cl; w_hl = (r_c >= CW'(2)); w_l = r_l2;
            w_hr = 1'b1; w_rr = r_cur;
            w_hd = (r_r != 16'd0); w_d = r_d2;
            w_jcol = r_c - CW'(1);
        end else if (r_jobs[2]) begin
            w_jsel = 3'b100;
            w_cc = r_cur; w_hl = (r_c != '0); w_l = r_cl;
            w_hd = (r_r != 16'd0); w_d = r_ctr;
        end
        w_gx = grad(w_cc, w_hl, w_l, w_hr, w_rr);
        w_gy = grad(w_cc, w_hd, w_d, w_hu, w_u);
        w_req.ok = w_cc.ok && (w_gx.ok || w_gy.ok);
        w_req.nx = w_gx.n;
        w_req.ny = w_gy.n;
        w_req.cs = r_cs;
    end

    assign w_start = (r_state == S_JOB) && (r_jobs != 3'b000);
    assign w_take  = (r_state == S_WAIT) && w_stat.done && (!r_out_vld || i_out_ready);

    egs_slope_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_slope (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_req         (w_req),
        .i_ack         (w_take),
        .o_stat        (w_stat),
        .o_slope       (w_slope),
        .o_slope_valid (w_slope_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_held0   <= '0;
            r_held1   <= '0;
            r_jobs    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_c      <= (r_col >= w_w_eff) ? '0 : r_col;
                        r_r      <= (r_row >= w_h_eff) ? 16'd0 : r_row;
                        r_w      <= w_w_eff;
                        r_h      <= w_h_eff;
                        r_cs     <= w_cs_eff;
                        r_cur.ok <= i_finite && (i_confidence >= r_cfg_floor);
                        r_cur.h  <= i_height;
                        r_pl     <= r_held0;
                        r_cl     <= r_held1;
                        r_state  <= S_RD0;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_ctr   <= w_prev_rd;
                    r_dn    <= w_older_rd;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_rgt   <= w_prev_rd;
                    r_d2    <= w_older_rd;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_l2    <= w_prev_rd;
                    r_held0 <= r_ctr;
                    r_held1 <= r_cur;
                    r_jobs  <= {(w_r_inc == {1'b0, r_h}) && (w_c_inc == r_w),
                                (w_r_inc == {1'b0, r_h}) && (r_c != '0),
                                (r_r != 16'd0)};
                    // advance raster position
                    if (w_c_inc >= r_w) begin
                        r_col <= '0;
                        r_row <= (w_r_inc >= {1'b0, r_h}) ? 16'd0 : w_r_inc[15:0];
                    end else begin
                        r_col <= w_c_inc;
                        r_row <= r_r;
                    end
                    r_state <= S_JOB;
                end
                S_JOB: begin
                    if (r_jobs == 3'b000) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_jobs     <= r_jobs & ~w_jsel;
                        r_job_last <= ((r_jobs & ~w_jsel) == 3'b000);
                        r_job_col  <= w_jcol;
                        r_job_row  <= w_jrow;
                        r_state    <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_take) begin
                        r_out_col   <= 10'(r_job_col);
                        r_out_row   <= r_job_row;
                        r_out_slope <= w_slope;
                        r_out_sv    <= w_slope_valid;
                        r_out_last  <= r_job_last;
                        r_state     <= S_JOB;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_column      = r_out_col;
    assign o_grid_row    = r_out_row;
    assign o_slope       = r_out_slope;
    assign o_slope_valid = r_out_sv;
    assign o_run_last    = r_out_last;

    `EGS_ASSERT_IMP(a_ready_unit_idle, i_clk, i_rst_n, o_in_ready, !w_stat.busy, "slope unit busy while ready")
    `EGS_ASSERT_NXT(a_accept_blocks, i_clk, i_rst_n, w_accept, !o_in_ready, "ready right after a beat")
    `EGS_ASSERT_IMP(a_nan_zero, i_clk, i_rst_n, o_out_valid && !o_slope_valid, o_slope == 14'd0, "invalid slope nonzero")
    `EGS_ASSERT_IMP(a_slope_range, i_clk, i_rst_n, o_out_valid, o_slope <= 14'd9000, "slope above vertical")

endmodule

// ----- bench/elevation_grid_slope_core_test.sv -----
// ---------------------------------------------------------------------------
// elevation_grid_slope_core_test
// Streams raster grids of height cells through the slope core under random
// input gaps and output stalls, predicts every slope result with a local
// central-difference / CORDIC model and checks each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module elevation_grid_slope_core_test;
    import egs_pkg::*;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE   = 2'd2;
    localparam logic [1:0] REG_CONF_FLOOR  = 2'd3;
    localparam int ROW_DEPTH   = 1024;
    localparam int TARGET_CELLS = 420;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 250;

    localparam longint ATAN_STEP [16] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459
    };

    typedef struct {
        logic signed [19:0] height;
        logic        [7:0]  confidence;
        logic               finite;
    } t_cell_in;

    typedef struct {
        logic [9:0]  column;
        logic [15:0] grid_row;
        logic [13:0] slope;
        logic        slope_valid;
        logic        run_last;
    } t_slope_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [19:0] i_height = '0;
    logic        [7:0]  i_confidence = '0;
    logic               i_finite = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic        [9:0]  o_column;
    logic        [15:0] o_grid_row;
    logic        [13:0] o_slope;
    logic               o_slope_valid;
    logic               o_run_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic        [1:0]  i_cfg_index = '0;
    logic        [15:0] i_cfg_data = '0;

    elevation_grid_slope_core u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_cell_in   cell_feed[$];
    t_slope_res slope_expect[$];
    bit         failed = 1'b0;
    int         cells_queued = 0;
    int         hold_cycles = 0;
    bit         no_idle = 1'b0;

    // Local copy of the grid state and registers
    t_cell       prev_row[ROW_DEPTH];
    t_cell       older_row[ROW_DEPTH];
    t_cell       left_prev, left_cur;
    int          col_pos = 0, row_pos = 0;
    logic [10:0] grid_w = 11'd1;
    logic [15:0] grid_h = 16'd1, cell_mm = 16'd100;
    logic [7:0]  conf_floor = 8'd0;

    function automatic int eff_width();
        if (grid_w == 0) return 1;
        if (grid_w > ROW_DEPTH) return ROW_DEPTH;
        return grid_w;
    endfunction

    function automatic int eff_height();
        return (grid_h == 0) ? 1 : grid_h;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned slope_angle(longint num, longint den);
        longint x = den, y = num, z = 0, dx, dy;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_STEP[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_STEP[i];
            end
        end
        if (z < 0) z = 0;
        z = (z + 32768) >>> 16;
        return (z > 9000) ? 9000 : int'(z);
    endfunction

    // Central difference, else forward, else backward; numerator over 2*cs.
    function automatic bit pick_gradient(t_cell c, bit hl, t_cell l, bit hr, t_cell r,
                                         output longint n);
        n = 0;
        if (hl && hr && l.ok && r.ok) begin
            n = longint'(r.h) - longint'(l.h);
            return 1'b1;
        end
        if (hr && r.ok) begin
            n = 2 * (longint'(r.h) - longint'(c.h));
            return 1'b1;
        end
        if (hl && l.ok) begin
            n = 2 * (longint'(c.h) - longint'(l.h));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_slope(int col, int row, t_cell c,
                                      bit hl, t_cell l, bit hr, t_cell r,
                                      bit hd, t_cell d, bit hu, t_cell u, int cs);
        longint nx = 0, ny = 0;
        longint unsigned ax, ay, m;
        bit gx = 1'b0, gy = 1'b0;
        t_slope_res res;
        res.column = col[9:0];
        res.grid_row = row[15:0];
        res.slope = '0;
        res.slope_valid = 1'b0;
        res.run_last = 1'b0;
        if (c.ok) begin
            gx = pick_gradient(c, hl, l, hr, r, nx);
            gy = pick_gradient(c, hd, d, hu, u, ny);
        end
        if (gx || gy) begin
            ax = (nx < 0) ? -nx : nx;
            ay = (ny < 0) ? -ny : ny;
            m = int_sqrt((ax * ax + ay * ay) << 20);
            res.slope_valid = 1'b1;
            if (m != 0)
                res.slope = 14'(slope_angle(longint'(m), longint'(2 * cs) << 10));
        end
        slope_expect.push_back(res);
    endfunction

    function automatic void predict_cell(t_cell_in cin);
        int w = eff_width(), hh = eff_height();
        int cs = (cell_mm == 0) ? 1 : cell_mm;
        int c, r, prior_count;
        t_cell cur, none, ctr, rgt, dn, pl, cl, l2, d2;
        none = '0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= hh) row_pos = 0;
        c = col_pos;
        r = row_pos;
        cur.h = cin.height;
        cur.ok = cin.finite && (cin.confidence >= conf_floor);
        ctr = prev_row[c];
        rgt = (c + 1 < w) ? prev_row[c + 1] : none;
        dn = older_row[c];
        pl = left_prev;
        cl = left_cur;
        prior_count = slope_expect.size();
        if (r >= 1)
            add_slope(c, r - 1, ctr, c > 0, pl, c + 1 < w, rgt, r >= 2, dn, 1'b1, cur, cs);
        older_row[c] = prev_row[c];
        prev_row[c] = cur;
        left_prev = ctr;
        left_cur = cur;
        // Last row: flush the cell to the left, and the row end at once
        if (r + 1 == hh) begin
            if (c >= 1) begin
                l2 = (c >= 2) ? prev_row[c - 2] : none;
                d2 = older_row[c - 1];
                add_slope(c - 1, r, cl, c >= 2, l2, 1'b1, cur, r >= 1, d2, 1'b0, none, cs);
            end
            if (c + 1 == w)
                add_slope(c, r, cur, c >= 1, cl, 1'b0, none, r >= 1, older_row[c],
                          1'b0, none, cs);
        end
        if (slope_expect.size() > prior_count)
            slope_expect[slope_expect.size() - 1].run_last = 1'b1;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= hh) row_pos = 0;
        end
    endfunction

    function automatic int gap_len();
        int sel = $urandom_range(0, 99);
        if (no_idle || sel < 50) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Input driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                predict_cell('{i_height, i_confidence, i_finite});
            if (in_gap > 0 || cell_feed.size() == 0) begin
                if (in_gap > 0) in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else begin
                t_cell_in nxt;
                nxt = cell_feed.pop_front();
                i_height <= nxt.height;
                i_confidence <= nxt.confidence;
                i_finite <= nxt.finite;
                i_in_valid <= 1'b1;
                in_gap <= gap_len();
            end
        end
    end

    // Output monitor
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (slope_expect.size() == 0) begin
                    $error("unexpected result beat: column %0d row %0d", o_column, o_grid_row);
                    failed = 1'b1;
                end else begin
                    t_slope_res e;
                    e = slope_expect.pop_front();
                    if (o_column !== e.column) begin
                        $error("column: expected %0d, got %0d", e.column, o_column);
                        failed = 1'b1;
                    end
                    if (o_grid_row !== e.grid_row) begin
                        $error("grid_row: expected %0d, got %0d", e.grid_row, o_grid_row);
                        failed = 1'b1;
                    end
                    if (o_slope !== e.slope) begin
                        $error("slope: expected %0d, got %0d", e.slope, o_slope);
                        failed = 1'b1;
                    end
                    if (o_slope_valid !== e.slope_valid) begin
                        $error("slope_valid: expected %0d, got %0d", e.slope_valid,
                               o_slope_valid);
                        failed = 1'b1;
                    end
                    if (o_run_last !== e.run_last) begin
                        $error("run_last: expected %0d, got %0d", e.run_last, o_run_last);
                        failed = 1'b1;
                    end
                end
            end
            // Long hold-off first, then ordinary random stalls
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready) out_gap <= gap_len();
            end
        end
    end

    // Watchdog on cycles without any beat
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("elevation_grid_slope_core test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GRID_WIDTH:  grid_w = data[10:0];
            REG_GRID_HEIGHT: grid_h = data;
            REG_CELL_SIZE:   cell_mm = data;
            REG_CONF_FLOOR:  conf_floor = data[7:0];
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int w, int h, int cs, int fl);
        write_reg(REG_GRID_WIDTH, 16'(w));
        write_reg(REG_GRID_HEIGHT, 16'(h));
        write_reg(REG_CELL_SIZE, 16'(cs));
        write_reg(REG_CONF_FLOOR, 16'(fl));
    endtask

    task automatic add_cell(int h, int conf, bit fin);
        cell_feed.push_back('{20'(h), 8'(conf), fin});
        cells_queued++;
    endtask

    int terrain_base = 0;
    task automatic add_random_cell();
        int sel = $urandom_range(0, 9);
        int h;
        if (sel == 0) h = int'($signed(20'($urandom)));
        else if (sel == 1) h = $urandom_range(0, 1) ? 524287 : -524288;
        else h = terrain_base + $urandom_range(0, 6000) - 3000;
        add_cell(h, (sel == 2) ? 255 : $urandom_range(0, 255), $urandom_range(0, 15) != 0);
    endtask

    // Wait until every beat is out, plus slack for items with no result
    task automatic drain();
        while (cell_feed.size() != 0 || i_in_valid || slope_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Finish the current grid so a wider one may start
    task automatic pad_grid();
        int w = eff_width(), hh = eff_height();
        int c = (col_pos >= w) ? 0 : col_pos;
        int r = (row_pos >= hh) ? 0 : row_pos;
        if (c != 0 || r != 0)
            for (int i = 0; i < (hh - r) * w - c; i++) add_random_cell();
        drain();
    endtask

    initial begin
        int w, h, cs, fl;
        foreach (prev_row[i]) begin
            prev_row[i] = '0;
            older_row[i] = '0;
        end
        left_prev = '0;
        left_cur = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-cell grid from reset: no gradient anywhere
        add_cell(0, 0, 1'b1);
        add_cell(524287, 255, 1'b1);
        add_cell(-524288, 0, 1'b1);
        add_cell(1234, 200, 1'b0);
        drain();

        // 3x3, finest spacing: extremes, floor edge, non-finite neighbors
        set_grid(3, 3, 1, 128);
        add_cell(-524288, 255, 1'b1);
        add_cell(524287, 255, 1'b1);
        add_cell(0, 200, 1'b1);
        add_cell(524287, 128, 1'b1);
        add_cell(100, 127, 1'b1);
        add_cell(-7, 255, 1'b0);
        add_cell(0, 255, 1'b1);
        add_cell(0, 255, 1'b1);
        add_cell(0, 255, 1'b1);
        drain();

        // Zero registers act as one
        set_grid(0, 0, 0, 0);
        add_cell(-1, 0, 1'b1);
        add_cell(5, 1, 1'b1);
        drain();

        // 2x2, coarsest spacing, full confidence only; flat cells
        set_grid(2, 2, 65535, 255);
        add_cell(10, 255, 1'b1);
        add_cell(10, 255, 1'b1);
        add_cell(10, 255, 1'b1);
        add_cell(-524288, 254, 1'b1);
        drain();

        // Oversize width, tall grid, then shrink both mid-grid
        set_grid(2047, 65535, 50, 10);
        for (int i = 0; i < 25; i++) add_random_cell();
        drain();
        write_reg(REG_GRID_WIDTH, 16'd4);
        for (int i = 0; i < 6; i++) add_random_cell();
        drain();
        write_reg(REG_GRID_HEIGHT, 16'd1);
        pad_grid();

        while (cells_queued < TARGET_CELLS) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            if ($urandom_range(0, 15) == 0) w = 40;
            h = $urandom_range(1, 6);
            if (w * h > 120) h = 120 / w;
            case ($urandom_range(0, 5))
                0: cs = 1;
                1: cs = 65535;
                2: cs = $urandom_range(1, 65535);
                default: cs = $urandom_range(20, 3000);
            endcase
            fl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
            set_grid(w, h, cs, fl);
            terrain_base = $urandom_range(0, 800000) - 400000;
            no_idle = ($urandom_range(0, 4) == 0);
            // Stall the output long enough to back up the input
            if (hold_cycles == 0 && cells_queued < 150) hold_cycles = 3000;
            for (int g = $urandom_range(1, 2); g > 0; g--)
                for (int i = 0; i < w * h; i++) add_random_cell();
            drain();
        end

        if (!failed)
            $display("elevation_grid_slope_core test passed");
        else
            $display("elevation_grid_slope_core test failed");
        $finish;
    end

endmodule
